[rtl/frcre_pkg.sv]
// Shared types and constants of the frame checksum receiver with echo.
// No dependencies; imported by every other file of the block.
package frcre_pkg;

	localparam int FRAME_LENGTH = 11;
	localparam int BYTE_W       = 8;
	localparam int IDX_W        = $clog2(FRAME_LENGTH);
	localparam int NUM_BANKS    = 2;
	localparam int BANK_W       = $clog2(NUM_BANKS);
	localparam int ADDR_W       = BANK_W + IDX_W;
	localparam int MEM_DEPTH    = NUM_BANKS * (2 ** IDX_W);
	localparam int QDEPTH       = NUM_BANKS;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LENGTH - 1);

	localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'h5A;
	localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'hA5;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_HEADER  = 2'd0,
		REG_SECOND_HEADER = 2'd1
	} cfg_reg_t;

	// frame store write from the parser into the echo buffer
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

	// good-frame token pushed into the queue
	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} frame_tok_t;

	// queue status seen by both sides
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [BANK_W-1:0] head;
	} q_status_t;

endpackage

[rtl/frcre_rx_if.sv]
// Receive channel: one serial byte per transfer.
// Depends on frcre_pkg.
interface frcre_rx_if;
	import frcre_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/frcre_tx_if.sv]
// Echo channel: one byte of a validated frame per transfer.
// Depends on frcre_pkg.
interface frcre_tx_if;
	import frcre_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] echo_byte;
	logic              last_byte;

	modport source (output valid, output echo_byte, output last_byte, input ready);
	modport sink   (input valid, input echo_byte, input last_byte, output ready);
endinterface

[rtl/frame_checksum_receiver_echo.sv]
// Frame checksum receiver with echo: two-byte header hunt, additive checksum,
// validated frames echoed byte by byte with a last marker.
// Input: one byte per cycle while a buffer bank is free (two banks).
// Output: the buffer read then hold sequencer fetches each echo byte, then holds it until taken;
// the first echo byte shows once the frame's token is queued and its buffer read is done.
// Reset (arst_n low) clears parser, queue and sequencer; headers return to 0x5A/0xA5.
module frame_checksum_receiver_echo (
	input  logic                            clk,
	input  logic                            arst_n,
	frcre_rx_if.sink                        rx,
	frcre_tx_if.source                      tx,
	input  logic                            cfg_we,
	input  logic [frcre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frcre_pkg::CFG_DATA_W-1:0] cfg_data
);
	import frcre_pkg::*;

	mem_wr_t    mem_wr;
	frame_tok_t push;
	q_status_t  q_stat;
	logic       pop;

	frcre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.mem_wr    (mem_wr)
	);

	frcre_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.q_stat (q_stat)
	);

	frcre_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.mem_wr (mem_wr),
		.q_stat (q_stat),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

[rtl/frcre_front.sv]
// Front end: header hunt, frame byte capture and checksum compare.
// Depends on frcre_pkg and frcre_rx_if; feeds frcre_back and frcre_queue.
module frcre_front (
	input  logic                           clk,
	input  logic                           arst_n,
	frcre_rx_if.sink                       rx,
	input  logic                           cfg_we,
	input  logic [frcre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frcre_pkg::CFG_DATA_W-1:0] cfg_data,
	input  frcre_pkg::q_status_t           q_stat,
	output frcre_pkg::frame_tok_t          push,
	output frcre_pkg::mem_wr_t             mem_wr
);
	import frcre_pkg::*;

	logic [BYTE_W-1:0] first_q;
	logic [BYTE_W-1:0] second_q;
	logic [IDX_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BANK_W-1:0] bank_q;

	logic [IDX_W-1:0]  pos_d;
	logic [BYTE_W-1:0] sum_d;
	logic [BYTE_W-1:0] b;
	logic              acc;
	logic              is_last;

	// a free bank is needed before taking bytes
	assign rx.ready = !q_stat.full;
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign is_last  = (pos_q == LAST_IDX);

	// parser next state and buffer write
	always_comb begin
		pos_d       = pos_q;
		sum_d       = sum_q;
		mem_wr.en   = 1'b0;
		mem_wr.addr = {bank_q, pos_q};
		mem_wr.data = b;
		push.valid  = 1'b0;
		push.bank   = bank_q;
		if (acc) begin
			priority if (pos_q == '0) begin
				if (b == first_q) begin
					mem_wr.en = 1'b1;
					sum_d     = b;
					pos_d     = IDX_W'(1);
				end
			end else if (pos_q == IDX_W'(1)) begin
				if (b == second_q) begin
					mem_wr.en = 1'b1;
					sum_d     = sum_q + b;
					pos_d     = IDX_W'(2);
				end else begin
					// wrong second header: back to hunting, byte not rechecked
					pos_d = '0;
				end
			end else if (!is_last) begin
				mem_wr.en = 1'b1;
				sum_d     = sum_q + b;
				pos_d     = pos_q + IDX_W'(1);
			end else begin
				// checksum byte: hand the frame over on a match
				mem_wr.en  = 1'b1;
				push.valid = (sum_q == b);
				sum_d      = '0;
				pos_d      = '0;
			end
		end
	end

	// parser state, write bank and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			bank_q   <= '0;
			first_q  <= FIRST_HEADER_RST;
			second_q <= SECOND_HEADER_RST;
		end else begin
			pos_q <= pos_d;
			sum_q <= sum_d;
			if (push.valid) begin
				bank_q <= bank_q + BANK_W'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIRST_HEADER:  first_q  <= cfg_data[BYTE_W-1:0];
					REG_SECOND_HEADER: second_q <= cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_stat.full)
		else $error("frame token pushed into a full queue");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_IDX)
		else $error("frame position beyond frame length");

endmodule

[rtl/frcre_queue.sv]
// Short queue of good-frame tokens (bank numbers) between front and back.
// Depends on frcre_pkg.
module frcre_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  frcre_pkg::frame_tok_t  push,
	input  logic                   pop,
	output frcre_pkg::q_status_t   q_stat
);
	import frcre_pkg::*;

	logic [BANK_W-1:0] entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.head  = entry_q[rd_ptr_q];

	// entries
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.bank;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

endmodule

[rtl/frcre_back.sv]
// Back end: double-banked frame buffer and byte-by-byte echo sequencer.
// Depends on frcre_pkg and frcre_tx_if; fed by frcre_front and frcre_queue.
module frcre_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  frcre_pkg::mem_wr_t    mem_wr,
	input  frcre_pkg::q_status_t  q_stat,
	output logic                  pop,
	frcre_tx_if.source            tx
);
	import frcre_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} state_t;

	state_t            st_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BANK_W-1:0] bank_q;
	logic [BYTE_W-1:0] rdata_q;
	logic              last_q;
	logic [BYTE_W-1:0] frame_mem_q [MEM_DEPTH];

	logic              out_xfer;

	assign tx.valid     = (st_q == ST_SHOW);
	assign tx.echo_byte = rdata_q;
	assign tx.last_byte = last_q;
	assign out_xfer     = tx.valid && tx.ready;
	// the bank is released once its checksum byte is transferred
	assign pop          = out_xfer && last_q;

	// frame buffer: write from the parser, registered read for the echo
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			frame_mem_q[mem_wr.addr] <= mem_wr.data;
		end
		if (st_q == ST_READ) begin
			rdata_q <= frame_mem_q[{bank_q, idx_q}];
			last_q  <= (idx_q == LAST_IDX);
		end
	end

	// echo sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			idx_q  <= '0;
			bank_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						bank_q <= q_stat.head;
						idx_q  <= '0;
						st_q   <= ST_READ;
					end
				end
				ST_READ: begin
					st_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_xfer) begin
						if (last_q) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							st_q  <= ST_READ;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_read_then_show: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |=> (st_q == ST_SHOW) && (last_q == ($past(idx_q) == LAST_IDX)))
		else $error("buffer read not followed by its output byte");

	a_no_write_to_echo_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) && mem_wr.en |-> (mem_wr.addr[ADDR_W-1 -: BANK_W] != bank_q))
		else $error("parser wrote into the bank being echoed");

endmodule
